FILE: hw/rtl/cctc_pkg.sv
package cctc_pkg;

	typedef enum logic [1:0] {
		CMD_LOAD        = 2'd0,
		CMD_STORE       = 2'd1,
		CMD_SNOOP_LOAD  = 2'd2,
		CMD_SNOOP_STORE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_INVALID  = 2'd0,
		ST_VALID    = 2'd1,
		ST_SHARED   = 2'd2,
		ST_MODIFIED = 2'd3
	} coh_state_t;

	localparam logic PROTO_VI  = 1'b0;
	localparam logic PROTO_MSI = 1'b1;

	typedef struct packed {
		logic hit;
		logic victim_dirty;
		logic shared_upgrade;
	} cc_result_t;

endpackage

FILE: hw/rtl/cctc_ram.sv
module cctc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/cctc_update.sv
module cctc_update
	import cctc_pkg::*;
#(
	parameter int NWAY  = 2,
	parameter int TAG_W = 19
) (
	input  cmd_t                        cmd,
	input  logic [TAG_W-1:0]            tag,
	input  logic                        protocol,
	input  logic [NWAY-1:0][TAG_W-1:0]  old_tags,
	input  logic [NWAY-1:0][1:0]        old_states,
	input  logic [NWAY-1:0]             old_dirty,
	input  logic                        old_lru,
	output logic [NWAY-1:0][TAG_W-1:0]  new_tags,
	output logic [NWAY-1:0][1:0]        new_states,
	output logic [NWAY-1:0]             new_dirty,
	output logic                        new_lru,
	output cc_result_t                  result
);

	logic [NWAY-1:0] match;
	logic [NWAY-1:0] hsel;
	logic [NWAY-1:0] fsel;
	logic            any_match;
	logic            hit_way;
	logic            fill_way;
	logic            sel_shared;
	logic            is_local;

	always_comb begin
		for (int w = 0; w < NWAY; w++) begin
			match[w] = (old_states[w] != ST_INVALID) && (old_tags[w] == tag);
		end
		// way 0 wins when both match
		hsel[0] = match[0];
		for (int w = 1; w < NWAY; w++) begin
			hsel[w] = match[w] && !match[0];
		end
		any_match = |match;
		hit_way   = (NWAY == 2) ? !match[0] : 1'b0;
		fill_way  = (NWAY == 2) ? old_lru : 1'b0;
		for (int w = 0; w < NWAY; w++) begin
			fsel[w] = (1'(w) == fill_way);
		end
		sel_shared = 1'b0;
		for (int w = 0; w < NWAY; w++) begin
			if (hsel[w] && old_states[w] == ST_SHARED) begin
				sel_shared = 1'b1;
			end
		end
		is_local = (cmd == CMD_LOAD) || (cmd == CMD_STORE);
	end

	always_comb begin
		new_tags   = old_tags;
		new_states = old_states;
		new_dirty  = old_dirty;
		new_lru    = old_lru;
		result     = '0;
		if (any_match) begin
			unique case (cmd)
				CMD_LOAD: begin
					result.hit = 1'b1;
					new_lru    = (NWAY == 2) ? !hit_way : 1'b0;
				end
				CMD_STORE: begin
					new_dirty = old_dirty | hsel;
					new_lru   = (NWAY == 2) ? !hit_way : 1'b0;
					if (sel_shared) begin
						result.shared_upgrade = 1'b1;
						for (int w = 0; w < NWAY; w++) begin
							if (hsel[w]) new_states[w] = ST_MODIFIED;
						end
					end else begin
						result.hit = 1'b1;
					end
				end
				CMD_SNOOP_LOAD: begin
					result.hit          = 1'b1;
					result.victim_dirty = |(old_dirty & hsel);
					for (int w = 0; w < NWAY; w++) begin
						if (hsel[w]) begin
							new_states[w] = (protocol == PROTO_MSI) ? ST_SHARED : ST_INVALID;
						end
					end
				end
				CMD_SNOOP_STORE: begin
					result.hit          = 1'b1;
					result.victim_dirty = |(old_dirty & hsel);
					for (int w = 0; w < NWAY; w++) begin
						if (hsel[w]) new_states[w] = ST_INVALID;
					end
				end
				default: ;
			endcase
		end else if (is_local) begin
			result.victim_dirty = |(old_dirty & fsel);
			new_lru = (NWAY == 2) ? !fill_way : 1'b0;
			for (int w = 0; w < NWAY; w++) begin
				if (fsel[w]) begin
					new_tags[w]  = tag;
					new_dirty[w] = (cmd == CMD_STORE);
					if (protocol == PROTO_MSI) begin
						new_states[w] = (cmd == CMD_STORE) ? ST_MODIFIED : ST_SHARED;
					end else begin
						new_states[w] = ST_VALID;
					end
				end
			end
		end
	end

endmodule

FILE: hw/rtl/coherent_cache_tag_controller.sv
// channel   | handshake             | payload
// ----------+-----------------------+---------------------------------
// request   | req_valid, req_stall  | command, address
// response  | rsp_valid, rsp_stall  | hit, victim_dirty, shared_upgrade
// config    | cfg_wr_en             | cfg_wr_data (coherence protocol)
//
// One request per cycle while req_stall is low; the set row is read at acceptance,
// then updated, written back and the response registered when the stage advances.
// A back-to-back request to the same set takes the row from a forwarding register.
// After reset a clearing pass writes every set once, holding req_stall high meanwhile.
// A stalled response holds the update stage; further requests stall behind it.
module coherent_cache_tag_controller
	import cctc_pkg::*;
#(
	parameter int SETS        = 256,
	parameter int OFFSET_BITS = 5,
	parameter int WAYS        = 2,
	parameter int ADDR_BITS   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  command,
	input  logic [31:0] address,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        hit,
	output logic        victim_dirty,
	output logic        shared_upgrade
);

	localparam int NWAY   = (WAYS >= 2) ? 2 : 1;
	localparam int IDX_W  = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int EFF_W  = (ADDR_BITS < 32) ? ADDR_BITS : 32;
	localparam int SH     = OFFSET_BITS + $clog2(SETS + 1) - 1;
	localparam int TAG_W  = (EFF_W > SH) ? EFF_W - SH : 1;
	localparam int ROW_W  = NWAY * (TAG_W + 3) + 1;
	localparam logic [31:0] ADDR_MASK =
		(ADDR_BITS >= 32) ? '1 : 32'((64'd1 << ADDR_BITS) - 64'd1);
	localparam logic [31:0] SET_MASK = 32'(SETS - 1);
	localparam logic [IDX_W-1:0] LAST_SET = IDX_W'(SETS - 1);

	logic             protocol_q;
	logic             clr_q;
	logic [IDX_W-1:0] clr_idx_q;

	logic             valid_s1;
	cmd_t             cmd_s1;
	logic [TAG_W-1:0] tag_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             fwd_s1;
	logic [ROW_W-1:0] wr_row_q;

	logic             rsp_valid_q;
	cc_result_t       result_q;

	logic [31:0]      eff_addr;
	logic [IDX_W-1:0] in_idx;
	logic [TAG_W-1:0] in_tag;
	logic             accept;
	logic             adv;

	logic [ROW_W-1:0] rd_row;
	logic [ROW_W-1:0] cur_row;
	logic [ROW_W-1:0] new_row;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [ROW_W-1:0] ram_wdata;

	logic [NWAY-1:0][TAG_W-1:0] old_tags, new_tags;
	logic [NWAY-1:0][1:0]       old_states, new_states;
	logic [NWAY-1:0]            old_dirty, new_dirty;
	logic                       old_lru, new_lru;
	cc_result_t                 result;

	assign eff_addr = address & ADDR_MASK;
	assign in_idx   = IDX_W'((eff_addr >> OFFSET_BITS) & SET_MASK);
	assign in_tag   = TAG_W'(eff_addr >> SH);

	assign adv       = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = clr_q || (valid_s1 && !adv);
	assign accept    = req_valid && !req_stall;

	// clearing pass owns the write port until it is done
	assign ram_we    = clr_q || adv;
	assign ram_waddr = clr_q ? clr_idx_q : idx_s1;
	assign ram_wdata = clr_q ? '0 : new_row;

	cctc_ram #(
		.WIDTH (ROW_W),
		.DEPTH (SETS)
	) u_row_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (in_idx),
		.rdata (rd_row)
	);

	assign cur_row = fwd_s1 ? wr_row_q : rd_row;
	assign {old_lru, old_dirty, old_states, old_tags} = cur_row;
	assign new_row = {new_lru, new_dirty, new_states, new_tags};

	cctc_update #(
		.NWAY  (NWAY),
		.TAG_W (TAG_W)
	) u_update (
		.cmd        (cmd_s1),
		.tag        (tag_s1),
		.protocol   (protocol_q),
		.old_tags   (old_tags),
		.old_states (old_states),
		.old_dirty  (old_dirty),
		.old_lru    (old_lru),
		.new_tags   (new_tags),
		.new_states (new_states),
		.new_dirty  (new_dirty),
		.new_lru    (new_lru),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			protocol_q <= PROTO_VI;
		end else if (cfg_wr_en) begin
			protocol_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == LAST_SET) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			// row being written this cycle is missed by the RAM read
			fwd_s1   <= adv && (idx_s1 == in_idx);
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_t'(command);
			tag_s1 <= in_tag;
			idx_s1 <= in_idx;
		end
		if (adv) begin
			wr_row_q <= new_row;
			result_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign hit            = result_q.hit;
	assign victim_dirty   = result_q.victim_dirty;
	assign shared_upgrade = result_q.shared_upgrade;

	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !valid_s1 && req_stall)
		else $error("request in flight during clearing pass");

	a_adv_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> rsp_valid)
		else $error("update stage advanced without a response");

	a_upgrade_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && shared_upgrade |-> !hit && !victim_dirty)
		else $error("upgrade miss reported with hit or dirty eviction");

	a_fwd_needs_write: assert property (@(posedge clk) disable iff (!arst_n)
		accept && adv && (idx_s1 == in_idx) |=> fwd_s1 && valid_s1)
		else $error("same-set request missed forwarding");

endmodule
